[hdl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the RGBE run-length scanline decoder: the
// line decoding modes, the error codes and the result record that travels
// from the decode stage to the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rrd_pkg;

   // Decoding mode of the current scanline. The three error modes are sticky.
   typedef enum logic [2:0] {
      MODE_START     = 3'd0,
      MODE_RAW       = 3'd1,
      MODE_LEAD      = 3'd2,
      MODE_RUNVAL    = 3'd3,
      MODE_LIT       = 3'd4,
      MODE_ERR_WIDTH = 3'd5,
      MODE_ERR_ZERO  = 3'd6,
      MODE_ERR_PAST  = 3'd7
   } mode_type;

   // Error codes carried on the result channel.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_WIDTH    = 2'd1;
   localparam logic [1:0] ERR_ZERO_LIT = 2'd2;
   localparam logic [1:0] ERR_PAST_END = 2'd3;

   // Line width after reset and the range that selects the run-length format.
   localparam logic [15:0] WIDTH_RESET = 16'd8;
   localparam logic [15:0] WIDTH_MIN   = 16'd8;
   localparam logic [15:0] WIDTH_MAX   = 16'h7fff;

   // Marker byte that opens a run-length scanline, and the run lead offset.
   localparam logic [7:0] MARK_BYTE = 8'd2;
   localparam logic [7:0] RUN_BASE  = 8'h80;

   // One decoded write, or a burst of four channel writes to pixel 0.
   typedef struct packed {
      logic             burst;
      logic [15:0]      pixel_index;
      logic [1:0]       channel;
      logic [6:0]       span_length;
      logic [3:0][7:0]  byte_value;
      logic             line_end;
      logic [1:0]       error_code;
   } result_type;

endpackage

`default_nettype wire

[hdl/rrd_core.sv]
// ----------------------------------------------------------------------------
// rrd_core
// Scanline decode state and the single-pass decode of one stream byte into
// at most one result record. The state advances when the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        line_width,
   input  wire logic               item_valid,
   input  wire logic [7:0]         item_byte,
   input  wire logic               out_free,
   output logic                    take,
   output logic                    res_valid,
   output rrd_pkg::result_type     res
);

   rrd_pkg::mode_type mode_ff, mode_in;
   logic [2:0][7:0]   mstore_ff, mstore_in;
   logic [1:0]        mcount_ff, mcount_in;
   logic [1:0]        plane_ff, plane_in;
   logic [15:0]       pix_ff, pix_in;
   logic [7:0]        oprem_ff, oprem_in;
   logic [17:0]       rawcnt_ff, rawcnt_in;

   logic        flat_width;
   logic [17:0] raw_base;
   logic [17:0] raw_total;
   logic [18:0] raw_next;
   logic        raw_end;
   logic        lead_is_run;
   logic [7:0]  lead_len;
   logic [16:0] lead_sum;
   logic        lead_over;
   logic [7:0]  oprem_dec;
   logic [7:0]  pix_step;
   logic [16:0] pix_sum;
   logic        plane_full;
   logic        marker_ok;

   // The byte is taken unless its result would find the result stage busy.
   assign take = item_valid && (!res_valid || out_free);

   // Raw byte addressing: a flat line starts counting at zero.
   assign flat_width = (line_width < rrd_pkg::WIDTH_MIN) || (line_width > rrd_pkg::WIDTH_MAX);
   assign raw_base   = (mode_ff == rrd_pkg::MODE_RAW) ? rawcnt_ff : 18'd0;
   assign raw_total  = {line_width, 2'b00};
   assign raw_next   = {1'b0, raw_base} + 19'd1;
   assign raw_end    = raw_next >= {1'b0, raw_total};

   // Lead byte: runs above 128, literals otherwise; bounds checked live.
   assign lead_is_run = item_byte > rrd_pkg::RUN_BASE;
   assign lead_len    = lead_is_run ? (item_byte - rrd_pkg::RUN_BASE) : item_byte;
   assign lead_sum    = {1'b0, pix_ff} + {9'd0, lead_len};
   assign lead_over   = lead_sum > {1'b0, line_width};

   // Pixel advance for run values and literal bytes.
   assign oprem_dec  = oprem_ff - 8'd1;
   assign pix_step   = (mode_ff == rrd_pkg::MODE_RUNVAL) ? oprem_ff : 8'd1;
   assign pix_sum    = {1'b0, pix_ff} + {9'd0, pix_step};
   assign plane_full = pix_sum >= {1'b0, line_width};

   assign marker_ok = (mstore_ff[0] == rrd_pkg::MARK_BYTE) &&
                      (mstore_ff[1] == rrd_pkg::MARK_BYTE) && !mstore_ff[2][7];

   // Next state and the result of the byte in the input register.
   always_comb begin
      mode_in   = mode_ff;
      mstore_in = mstore_ff;
      mcount_in = mcount_ff;
      plane_in  = plane_ff;
      pix_in    = pix_ff;
      oprem_in  = oprem_ff;
      rawcnt_in = rawcnt_ff;
      res_valid = 1'b0;
      res       = '0;

      unique case (mode_ff) inside
         rrd_pkg::MODE_START, rrd_pkg::MODE_RAW: begin
            if (mode_ff == rrd_pkg::MODE_RAW || (mcount_ff == 2'd0 && flat_width)) begin
               // Raw byte in R, G, B, E order per pixel.
               res_valid           = 1'b1;
               res.pixel_index     = raw_base[17:2];
               res.channel         = raw_base[1:0];
               res.span_length     = 7'd1;
               res.byte_value[0]   = item_byte;
               res.line_end        = raw_end;
               if (raw_end) begin
                  mode_in   = rrd_pkg::MODE_START;
                  rawcnt_in = 18'd0;
                  mcount_in = 2'd0;
               end else begin
                  mode_in   = rrd_pkg::MODE_RAW;
                  rawcnt_in = raw_next[17:0];
               end
            end else if (mcount_ff != 2'd3) begin
               mstore_in[mcount_ff] = item_byte;
               mcount_in            = mcount_ff + 2'd1;
            end else begin
               mcount_in = 2'd0;
               if (!marker_ok) begin
                  // Not a marker: its four bytes become pixel 0.
                  res_valid         = 1'b1;
                  res.burst         = 1'b1;
                  res.span_length   = 7'd1;
                  res.byte_value[0] = mstore_ff[0];
                  res.byte_value[1] = mstore_ff[1];
                  res.byte_value[2] = mstore_ff[2];
                  res.byte_value[3] = item_byte;
                  rawcnt_in         = 18'd4;
                  mode_in           = rrd_pkg::MODE_RAW;
               end else if ({mstore_ff[2], item_byte} != line_width) begin
                  res_valid      = 1'b1;
                  res.error_code = rrd_pkg::ERR_WIDTH;
                  mode_in        = rrd_pkg::MODE_ERR_WIDTH;
               end else begin
                  plane_in = 2'd0;
                  pix_in   = 16'd0;
                  oprem_in = 8'd0;
                  mode_in  = rrd_pkg::MODE_LEAD;
               end
            end
         end
         rrd_pkg::MODE_LEAD: begin
            if (!lead_is_run && item_byte == 8'd0) begin
               res_valid      = 1'b1;
               res.error_code = rrd_pkg::ERR_ZERO_LIT;
               mode_in        = rrd_pkg::MODE_ERR_ZERO;
            end else if (lead_over) begin
               res_valid      = 1'b1;
               res.error_code = rrd_pkg::ERR_PAST_END;
               mode_in        = rrd_pkg::MODE_ERR_PAST;
            end else begin
               oprem_in = lead_len;
               mode_in  = lead_is_run ? rrd_pkg::MODE_RUNVAL : rrd_pkg::MODE_LIT;
            end
         end
         rrd_pkg::MODE_RUNVAL, rrd_pkg::MODE_LIT: begin
            res_valid         = 1'b1;
            res.pixel_index   = pix_ff;
            res.channel       = plane_ff;
            res.span_length   = (mode_ff == rrd_pkg::MODE_RUNVAL) ? oprem_ff[6:0] : 7'd1;
            res.byte_value[0] = item_byte;
            pix_in            = pix_sum[15:0];
            oprem_in          = (mode_ff == rrd_pkg::MODE_RUNVAL) ? 8'd0 : oprem_dec;
            // The plane closes once its pixels are all written.
            if (mode_ff == rrd_pkg::MODE_RUNVAL || oprem_dec == 8'd0) begin
               mode_in = rrd_pkg::MODE_LEAD;
               if (plane_full) begin
                  pix_in = 16'd0;
                  if (plane_ff == 2'd3) begin
                     plane_in     = 2'd0;
                     mcount_in    = 2'd0;
                     mode_in      = rrd_pkg::MODE_START;
                     res.line_end = 1'b1;
                  end else begin
                     plane_in = plane_ff + 2'd1;
                  end
               end
            end
         end
         rrd_pkg::MODE_ERR_WIDTH: begin
            res_valid      = 1'b1;
            res.error_code = rrd_pkg::ERR_WIDTH;
         end
         rrd_pkg::MODE_ERR_ZERO: begin
            res_valid      = 1'b1;
            res.error_code = rrd_pkg::ERR_ZERO_LIT;
         end
         rrd_pkg::MODE_ERR_PAST: begin
            res_valid      = 1'b1;
            res.error_code = rrd_pkg::ERR_PAST_END;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Decode state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rrd_pkg::MODE_START;
         mstore_ff <= '0;
         mcount_ff <= 2'd0;
         plane_ff  <= 2'd0;
         pix_ff    <= 16'd0;
         oprem_ff  <= 8'd0;
         rawcnt_ff <= 18'd0;
      end else if (take) begin
         mode_ff   <= mode_in;
         mstore_ff <= mstore_in;
         mcount_ff <= mcount_in;
         plane_ff  <= plane_in;
         pix_ff    <= pix_in;
         oprem_ff  <= oprem_in;
         rawcnt_ff <= rawcnt_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rrd_out.sv]
// ----------------------------------------------------------------------------
// rrd_out
// Result register. Holds one decoded write, or a burst of four channel
// writes, and presents them on the result channel one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire rrd_pkg::result_type res,
   output logic                     out_free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_pixel_index,
   output logic [1:0]               rsp_channel,
   output logic [6:0]               rsp_span_length,
   output logic [7:0]               rsp_byte_value,
   output logic                     rsp_line_end,
   output logic [1:0]               rsp_error_code,
   output logic                     rsp_last_result
);

   logic [2:0]          rem_ff, rem_in;
   logic [1:0]          idx_ff, idx_in;
   rrd_pkg::result_type hold_ff, hold_in;

   // Free when empty or when the final write of the record leaves now.
   assign out_free  = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ready);
   assign rsp_valid = rem_ff != 3'd0;

   // Count down the writes of the record; a new record loads behind the last.
   always_comb begin
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      hold_in = hold_ff;
      if (rsp_valid && rsp_ready) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
      if (load) begin
         rem_in  = res.burst ? 3'd4 : 3'd1;
         idx_in  = 2'd0;
         hold_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // Result fields; a burst walks the channels of pixel 0.
   assign rsp_pixel_index = hold_ff.pixel_index;
   assign rsp_channel     = hold_ff.burst ? idx_ff : hold_ff.channel;
   assign rsp_span_length = hold_ff.span_length;
   assign rsp_byte_value  = hold_ff.byte_value[idx_ff];
   assign rsp_line_end    = hold_ff.line_end;
   assign rsp_error_code  = hold_ff.error_code;
   assign rsp_last_result = rem_ff == 3'd1;

endmodule

`default_nettype wire

[hdl/rgbe_rle_scanline_decoder.sv]
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder
// Decodes RGBE run-length scanlines one byte at a time into span writes.
// ----------------------------------------------------------------------------
// Usage:
//  - The req channel takes one stream byte per transfer. The rsp channel
//    gives span writes (pixel, channel, span length, byte value) with line
//    end, error code and a flag on the last write caused by the byte.
//  - The csr channel writes the line width and is always ready; the user must
//    only write it while no results are outstanding, which the block does not enforce.
//  - A byte is held in the input register and is decoded into the result
//    register when it is taken; its writes are offered from the result register.
//  - Throughput is one byte per cycle while the receiver is ready. A byte that
//    closes a non-matching marker gives four writes, which leave one at a time
//    while the input register holds the following byte.
//  - When the receiver stalls, the result register holds its write and the
//    input register fills, then req_ready falls; nothing is dropped.
//  - Reset empties both registers, restarts line decoding, clears any
//    sticky error and sets the line width to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_rle_scanline_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_line_width,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pixel_index,
   output logic [1:0]       rsp_channel,
   output logic [6:0]       rsp_span_length,
   output logic [7:0]       rsp_byte_value,
   output logic             rsp_line_end,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_result
);

   logic [15:0]         width_ff;
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                take;
   logic                out_free;
   logic                res_valid;
   rrd_pkg::result_type res;

   // Line width register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rrd_pkg::WIDTH_RESET;
      end else if (csr_valid) begin
         width_ff <= csr_line_width;
      end
   end

   // Input register; refills in the cycle its byte is taken.
   assign req_ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // Decode stage.
   rrd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .line_width (width_ff),
      .item_valid (in_valid_ff),
      .item_byte  (in_byte_ff),
      .out_free   (out_free),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Result stage.
   rrd_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (take && res_valid),
      .res             (res),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_channel     (rsp_channel),
      .rsp_span_length (rsp_span_length),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_line_end    (rsp_line_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_result (rsp_last_result)
   );

endmodule

`default_nettype wire

[hdl/rrd_checker.sv]
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the scanline decoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pixel_index,
   input wire logic [1:0]  rsp_channel,
   input wire logic [6:0]  rsp_span_length,
   input wire logic [7:0]  rsp_byte_value,
   input wire logic        rsp_line_end,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_last_result
);

   // A stalled write holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_index) &&
         $stable(rsp_channel) && $stable(rsp_byte_value) && $stable(rsp_error_code))
      else $error("stalled result changed");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Error writes carry no span and no line end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != rrd_pkg::ERR_NONE |->
         rsp_span_length == 7'd0 && rsp_pixel_index == 16'd0 && !rsp_line_end)
      else $error("error write carries data");

   // Good writes cover at least one pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == rrd_pkg::ERR_NONE |-> rsp_span_length != 7'd0)
      else $error("empty span write");

   // The write that completes a line is the only write of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_last_result)
      else $error("line end inside a burst");

endmodule

bind rgbe_rle_scanline_decoder rrd_checker u_rrd_checker (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Scanline decoder test: feeds flat lines, broken markers and run-length
// lines over several line widths, and predicts every span write in a
// scoreboard that decodes the accepted bytes itself. The run ends with
// one deliberate error so that the sticky error path is exercised too.
// ----------------------------------------------------------------------------

module testbench;

   // One span write as it appears on the result channel.
   typedef struct packed {
      logic [15:0] pixel_index;
      logic [1:0]  channel;
      logic [6:0]  span_length;
      logic [7:0]  byte_value;
      logic        line_end;
      logic [1:0]  error_code;
      logic        last_result;
   } span_write_type;

   // Decodes the accepted byte stream and holds the span writes still due.
   class scanline_checker;
      logic [15:0]       width;
      rrd_pkg::mode_type mode;
      logic [7:0]        marks [3];
      logic [1:0]        mark_cnt;
      logic [1:0]        plane;
      logic [19:0]       pos;
      logic [7:0]        op_left;
      logic [17:0]       raw_cnt;
      span_write_type    spans [$];
      int                errors;

      function new();
         width    = rrd_pkg::WIDTH_RESET;
         mode     = rrd_pkg::MODE_START;
         marks    = '{8'd0, 8'd0, 8'd0};
         mark_cnt = '0;
         plane    = '0;
         pos      = '0;
         op_left  = '0;
         raw_cnt  = '0;
         errors   = 0;
      endfunction

      function void set_width(logic [15:0] w);
         width = w;
      endfunction

      function int pending();
         return spans.size();
      endfunction

      function void push_span(logic [15:0] pix, logic [1:0] ch, logic [6:0] span,
                              logic [7:0] val, logic done, logic [1:0] code);
         span_write_type s;
         s = '{pix, ch, span, val, done, code, 1'b0};
         spans.insert(spans.size(), s);
      endfunction

      // One byte of a flat line; the line closes once 4 * width bytes are in.
      function void flat_byte(logic [7:0] b);
         logic [31:0] total;
         logic        done;
         total = {16'd0, width} * 4;
         done  = ({14'd0, raw_cnt} + 32'd1) >= total;
         push_span(raw_cnt[17:2], raw_cnt[1:0], 7'd1, b, done, rrd_pkg::ERR_NONE);
         if (done) begin
            mode     = rrd_pkg::MODE_START;
            raw_cnt  = '0;
            mark_cnt = '0;
         end else begin
            raw_cnt = raw_cnt + 18'd1;
         end
      endfunction

      function void flag_error(logic [1:0] code);
         case (code)
            rrd_pkg::ERR_WIDTH:    mode = rrd_pkg::MODE_ERR_WIDTH;
            rrd_pkg::ERR_ZERO_LIT: mode = rrd_pkg::MODE_ERR_ZERO;
            default:               mode = rrd_pkg::MODE_ERR_PAST;
         endcase
         push_span(16'd0, 2'd0, 7'd0, 8'd0, 1'b0, code);
      endfunction

      // Closes the plane when it is full; returns 1 when the line is done.
      function logic close_plane();
         mode = rrd_pkg::MODE_LEAD;
         if (pos < width) return 1'b0;
         pos = '0;
         if (plane == 2'd3) begin
            plane    = '0;
            mark_cnt = '0;
            mode     = rrd_pkg::MODE_START;
            return 1'b1;
         end
         plane = plane + 2'd1;
         return 1'b0;
      endfunction

      // Notes an accepted byte and queues the span writes it causes.
      function void accept_byte(logic [7:0] b);
         int          first;
         logic [19:0] p0;
         logic [1:0]  ch;
         logic [7:0]  cnt;
         logic        done;
         logic [1:0]  code;
         first = spans.size();
         case (mode)
            rrd_pkg::MODE_START: begin
               if (mark_cnt == 0 &&
                   (width < rrd_pkg::WIDTH_MIN || width > rrd_pkg::WIDTH_MAX)) begin
                  mode    = rrd_pkg::MODE_RAW;
                  raw_cnt = '0;
                  flat_byte(b);
               end else if (mark_cnt < 2'd3) begin
                  marks[mark_cnt] = b;
                  mark_cnt = mark_cnt + 2'd1;
               end else begin
                  mark_cnt = '0;
                  if (marks[0] != rrd_pkg::MARK_BYTE || marks[1] != rrd_pkg::MARK_BYTE ||
                      marks[2][7]) begin
                     // Not a marker: the four bytes are pixel 0 of a flat line.
                     push_span(16'd0, 2'd0, 7'd1, marks[0], 1'b0, rrd_pkg::ERR_NONE);
                     push_span(16'd0, 2'd1, 7'd1, marks[1], 1'b0, rrd_pkg::ERR_NONE);
                     push_span(16'd0, 2'd2, 7'd1, marks[2], 1'b0, rrd_pkg::ERR_NONE);
                     push_span(16'd0, 2'd3, 7'd1, b, 1'b0, rrd_pkg::ERR_NONE);
                     raw_cnt = 18'd4;
                     mode    = rrd_pkg::MODE_RAW;
                  end else if ({marks[2], b} != width) begin
                     flag_error(rrd_pkg::ERR_WIDTH);
                  end else begin
                     plane   = '0;
                     pos     = '0;
                     op_left = '0;
                     mode    = rrd_pkg::MODE_LEAD;
                  end
               end
            end
            rrd_pkg::MODE_RAW: flat_byte(b);
            rrd_pkg::MODE_LEAD: begin
               if (b > rrd_pkg::RUN_BASE) begin
                  cnt = b - rrd_pkg::RUN_BASE;
                  if (pos + cnt > width) begin
                     flag_error(rrd_pkg::ERR_PAST_END);
                  end else begin
                     op_left = cnt;
                     mode    = rrd_pkg::MODE_RUNVAL;
                  end
               end else if (b == 8'd0) begin
                  flag_error(rrd_pkg::ERR_ZERO_LIT);
               end else if (pos + b > width) begin
                  flag_error(rrd_pkg::ERR_PAST_END);
               end else begin
                  op_left = b;
                  mode    = rrd_pkg::MODE_LIT;
               end
            end
            rrd_pkg::MODE_RUNVAL: begin
               p0      = pos;
               ch      = plane;
               cnt     = op_left;
               pos     = pos + cnt;
               op_left = '0;
               done    = close_plane();
               push_span(p0[15:0], ch, cnt[6:0], b, done, rrd_pkg::ERR_NONE);
            end
            rrd_pkg::MODE_LIT: begin
               p0      = pos;
               ch      = plane;
               pos     = pos + 20'd1;
               op_left = op_left - 8'd1;
               done    = 1'b0;
               if (op_left == 8'd0) done = close_plane();
               push_span(p0[15:0], ch, 7'd1, b, done, rrd_pkg::ERR_NONE);
            end
            default: begin
               // Sticky error: every byte repeats the error write.
               case (mode)
                  rrd_pkg::MODE_ERR_WIDTH: code = rrd_pkg::ERR_WIDTH;
                  rrd_pkg::MODE_ERR_ZERO:  code = rrd_pkg::ERR_ZERO_LIT;
                  default:                 code = rrd_pkg::ERR_PAST_END;
               endcase
               push_span(16'd0, 2'd0, 7'd0, 8'd0, 1'b0, code);
            end
         endcase
         if (spans.size() > first) spans[spans.size() - 1].last_result = 1'b1;
      endfunction

      function string span_text(span_write_type s);
         return $sformatf("pix=%0d ch=%0d len=%0d val=%02h end=%0b err=%0d last=%0b",
                          s.pixel_index, s.channel, s.span_length, s.byte_value,
                          s.line_end, s.error_code, s.last_result);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Compares a transferred write with the oldest one still due.
      task match_span(span_write_type got);
         span_write_type want;
         string          bad;
         if (spans.size() == 0) begin
            report({"write with none expected: ", span_text(got)});
            return;
         end
         want = spans.pop_front();
         bad  = "";
         if (got.pixel_index !== want.pixel_index) bad = {bad, " pixel_index"};
         if (got.channel     !== want.channel)     bad = {bad, " channel"};
         if (got.span_length !== want.span_length) bad = {bad, " span_length"};
         if (got.byte_value  !== want.byte_value)  bad = {bad, " byte_value"};
         if (got.line_end    !== want.line_end)    bad = {bad, " line_end"};
         if (got.error_code  !== want.error_code)  bad = {bad, " error_code"};
         if (got.last_result !== want.last_result) bad = {bad, " last_result"};
         if (bad != "")
            report($sformatf("%s differ: got %s, expected %s", bad, span_text(got),
                             span_text(want)));
      endtask
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_line_width = 16'd0;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in    = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [15:0] rsp_pixel_index;
   logic [1:0]  rsp_channel;
   logic [6:0]  rsp_span_length;
   logic [7:0]  rsp_byte_value;
   logic        rsp_line_end;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_result;

   scanline_checker sb;
   span_write_type  seen;
   logic [7:0]      line_bytes [$];
   int              send_idle;
   int              recv_idle;

   rgbe_rle_scanline_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_line_width  (csr_line_width),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_channel     (rsp_channel),
      .rsp_span_length (rsp_span_length),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_line_end    (rsp_line_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_result (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check each transfer and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_pixel_index, rsp_channel, rsp_span_length, rsp_byte_value,
                     rsp_line_end, rsp_error_code, rsp_last_result};
            sb.match_span(seen);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic int min_of(int a, int b);
      return (a < b) ? a : b;
   endfunction

   // Offers one byte, with random gaps, and waits for its transfer.
   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.accept_byte(b);
   endtask

   // Holds the sender back until every predicted write has been transferred.
   task wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Writes the line width once the decoder has gone quiet.
   task write_width(input logic [15:0] w);
      wait_drain();
      repeat (6) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_line_width <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_width(w);
      csr_valid <= 1'b0;
   endtask

   task flush_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Appends one byte to the line being built.
   function void add_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function void add_flat(int n);
      repeat (n) add_byte(8'($urandom_range(255)));
   endfunction

   // A line that opens with a broken marker and goes on as flat bytes.
   function void add_mismatch(int w);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      b0 = rrd_pkg::MARK_BYTE;
      b1 = rrd_pkg::MARK_BYTE;
      b2 = 8'($urandom_range(255));
      case ($urandom_range(2))
         0: begin
            b0 = 8'($urandom_range(255));
            if (b0 == rrd_pkg::MARK_BYTE) b0 = 8'hff;
            b1 = 8'($urandom_range(255));
         end
         1: begin
            b1 = 8'($urandom_range(255));
            if (b1 == rrd_pkg::MARK_BYTE) b1 = 8'h00;
         end
         default: b2 = b2 | 8'h80;
      endcase
      add_byte(b0);
      add_byte(b1);
      add_byte(b2);
      add_flat(4 * w - 3);
   endfunction

   // A well-formed run-length line: marker, then four planes of runs and literals.
   function void add_rle(int w, bit long_ops);
      logic [15:0] wv;
      int          left;
      int          cnt;
      int          cap;
      wv = 16'(w);
      add_byte(rrd_pkg::MARK_BYTE);
      add_byte(rrd_pkg::MARK_BYTE);
      add_byte(wv[15:8]);
      add_byte(wv[7:0]);
      repeat (4) begin
         left = w;
         while (left > 0) begin
            if ($urandom_range(99) < (long_ops ? 80 : 50)) begin
               cap = min_of(127, left);
               cnt = (long_ops && $urandom_range(1) == 1) ? cap : $urandom_range(cap, 1);
               add_byte(8'(rrd_pkg::RUN_BASE + cnt));
               add_byte(8'($urandom_range(255)));
            end else begin
               cnt = $urandom_range(min_of(8, left), 1);
               add_byte(8'(cnt));
               add_flat(cnt);
            end
            left -= cnt;
         end
      end
   endfunction

   // Sends whole lines at one width until the byte budget is used up.
   // Flat lines may be left open when partial is set.
   task run_segment(input int w, input int budget, input bit partial);
      int sent;
      int n;
      int lines;
      write_width(16'(w));
      sent  = 0;
      lines = 0;
      while (sent < budget) begin
         if (sb.mode == rrd_pkg::MODE_RAW) begin
            // A flat line left open under an earlier width.
            n = (int'(sb.raw_cnt) + 1 >= 4 * w) ? 1 : 4 * w - int'(sb.raw_cnt);
            if (partial) n = min_of(n, budget - sent);
            add_flat(n);
         end else if (w < rrd_pkg::WIDTH_MIN || w > rrd_pkg::WIDTH_MAX) begin
            n = 4 * w;
            if (partial) n = min_of(n, budget - sent);
            add_flat(n);
         end else if (w < 64 && (lines == 0 || $urandom_range(3) == 0)) begin
            add_mismatch(w);
         end else begin
            add_rle(w, w > 127);
         end
         sent += line_bytes.size();
         lines++;
         flush_line();
         if ($urandom_range(3) == 0) wait_drain();
      end
   endtask

   // Closes the run with one error of a random kind, then a few sticky bytes.
   task end_with_error();
      int          code;
      int          w;
      int          first;
      int          cnt;
      logic [15:0] wv;
      code = $urandom_range(3, 1);
      w    = (code == rrd_pkg::ERR_PAST_END) ? $urandom_range(20, 8) :
                                               int'(rrd_pkg::WIDTH_MAX);
      wv   = 16'(w);
      write_width(wv);
      add_byte(rrd_pkg::MARK_BYTE);
      add_byte(rrd_pkg::MARK_BYTE);
      add_byte(wv[15:8]);
      case (code)
         rrd_pkg::ERR_WIDTH: begin
            // Marker width one pixel or more short of the register.
            add_byte(8'($urandom_range(254)));
         end
         rrd_pkg::ERR_ZERO_LIT: begin
            add_byte(wv[7:0]);
            repeat (2) begin
               add_byte(8'hff);
               add_byte(8'($urandom_range(255)));
            end
            add_byte(8'h00);
         end
         default: begin
            // A partial run, then a run or literal that overshoots the plane.
            add_byte(wv[7:0]);
            first = $urandom_range(w - 1, 1);
            add_byte(8'(rrd_pkg::RUN_BASE + first));
            add_byte(8'($urandom_range(255)));
            cnt = w - first + 1;
            add_byte($urandom_range(1) ? 8'(rrd_pkg::RUN_BASE + cnt) : 8'(cnt));
         end
      endcase
      add_flat(3);
      flush_line();
   endtask

   // Main sequence.
   initial begin
      sb        = new();
      send_idle = 33;
      recv_idle = 49;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Short directed lines: one-pixel flat line with extreme bytes,
      // zero width, and a minimum-width run-length line.
      write_width(16'd1);
      line_bytes = '{8'h00, 8'hff, 8'h55, 8'haa};
      flush_line();
      wait_drain();
      write_width(16'd0);
      line_bytes = '{8'h80, 8'h7f};
      flush_line();
      write_width(rrd_pkg::WIDTH_MIN);
      line_bytes = '{rrd_pkg::MARK_BYTE, rrd_pkg::MARK_BYTE, 8'h00, 8'h08, 8'h81, 8'h00,
                     8'h87, 8'hff, 8'h01, 8'h12, 8'h87, 8'h34, 8'h88, 8'h56, 8'h88,
                     8'h78};
      flush_line();

      // Random traffic in three idling phases.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 33;
               recv_idle = 49;
               run_segment(8, 33, 1'b0);
               run_segment(65535, 8, 1'b1);
            end
            1: begin
               send_idle = 49;
               recv_idle = 33;
               run_segment(3, 12, 1'b0);
               run_segment(255, 1, 1'b0);
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               run_segment(32768, 6, 1'b1);
               run_segment(7, 1, 1'b0);
            end
         endcase
      end
      end_with_error();

      wait_drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #1_000_000;
      $display("[%0t] timed out with %0d writes outstanding", $time, sb.pending());
      $display("TEST FAILED");
      $finish;
   end

endmodule
